[design/ssm_pkg.sv]
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, codes and default sizes for the sparse-set membership core.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // Default sizes; the top level takes these as parameter defaults.
  localparam int ID_SPACE_DEF    = 256;
  localparam int DENSE_DEPTH_DEF = 256;
  localparam int GEN_BITS_DEF    = 8;

  // Fixed field widths of the beats.
  localparam int ID_W  = 8;
  localparam int GEN_W = 8;
  localparam int IDX_W = 8;
  localparam int CNT_W = 9;

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_TEST   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Classified operation; OP_NONE answers "not present" without touching state.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TEST   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [GEN_W-1:0] gen;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] dense_index;
    logic             move_payload;
    logic [IDX_W-1:0] moved_from_index;
    logic [CNT_W-1:0] active_count;
  } result_t;

endpackage

[design/sparse_set_membership_core.sv]
// Paths: add, unused codes and ids with no sparse entry answer from the lookup
//   state, a dense compare adds the match state, a remove hit adds the finish state.
// Sequencing: the back sequencer runs one beat at a time through its dependent
//   sparse-then-dense memory reads; the queue holds 2 beats meanwhile.
// Reset: synchronous; afterwards in_stall stays high while the sparse memory's
//   min(ID_SPACE, 256) entries are swept to invalid, one entry per cycle.
// ----------------------------------------------------------------------------
// sparse_set_membership_core
// Sparse-set table of entity ids with packed dense slots and swap-and-pop
// removal. Front classifies beats, a queue decouples, back runs the memories.
// ----------------------------------------------------------------------------
module sparse_set_membership_core import ssm_pkg::*; #(
  parameter int ID_SPACE    = ID_SPACE_DEF,
  parameter int DENSE_DEPTH = DENSE_DEPTH_DEF,
  parameter int GEN_BITS    = GEN_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       func,
  input  logic [ID_W-1:0]  entity_id,
  input  logic [GEN_W-1:0] entity_generation,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [IDX_W-1:0] dense_index,
  output logic             move_payload,
  output logic [IDX_W-1:0] moved_from_index,
  output logic [CNT_W-1:0] active_count
);

  logic    push;
  cmd_t    push_cmd;
  logic    q_full;
  logic    q_valid;
  cmd_t    q_cmd;
  logic    pop;
  logic    clearing;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_res;

  // Front: decode func, range-check the id, mask the generation.
  ssm_front #(
    .ID_SPACE (ID_SPACE),
    .GEN_BITS (GEN_BITS)
  ) u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .func              (func),
    .entity_id         (entity_id),
    .entity_generation (entity_generation),
    .q_full            (q_full),
    .clearing          (clearing),
    .push              (push),
    .cmd               (push_cmd)
  );

  // Queue: hold classified commands while the back is busy.
  ssm_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // Back: sequence the sparse and dense memory accesses for one command.
  ssm_back #(
    .ID_SPACE    (ID_SPACE),
    .DENSE_DEPTH (DENSE_DEPTH),
    .GEN_BITS    (GEN_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load a finished result whenever the slot is empty or
  // being drained this cycle; hold it while the receiver stalls.
  assign res_ready = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  // Drive the result beat fields.
  assign status           = out_res.status;
  assign dense_index      = out_res.dense_index;
  assign move_payload     = out_res.move_payload;
  assign moved_from_index = out_res.moved_from_index;
  assign active_count     = out_res.active_count;

endmodule

[design/ssm_front.sv]
// ----------------------------------------------------------------------------
// ssm_front
// Accepts input beats, decodes the function, range-checks the id and masks
// the generation into a queued command.
// ----------------------------------------------------------------------------
module ssm_front import ssm_pkg::*; #(
  parameter int ID_SPACE = ID_SPACE_DEF,
  parameter int GEN_BITS = GEN_BITS_DEF
) (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       func,
  input  logic [ID_W-1:0]  entity_id,
  input  logic [GEN_W-1:0] entity_generation,
  input  logic             q_full,
  input  logic             clearing,
  output logic             push,
  output cmd_t             cmd
);

  localparam logic [GEN_W-1:0] GEN_MASK =
    (GEN_BITS >= GEN_W) ? {GEN_W{1'b1}} : GEN_W'((64'd1 << GEN_BITS) - 64'd1);

  logic id_ok;

  assign id_ok    = {24'd0, entity_id} < 32'(ID_SPACE);
  assign in_stall = q_full | clearing;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    cmd.id  = entity_id;
    cmd.gen = entity_generation & GEN_MASK;
    cmd.op  = OP_NONE;
    if (id_ok) begin
      unique case (func)
        FN_ADD:    cmd.op = OP_ADD;
        FN_REMOVE: cmd.op = OP_REMOVE;
        FN_TEST:   cmd.op = OP_TEST;
        default:   cmd.op = OP_NONE;
      endcase
    end
  end

endmodule

[design/ssm_queue.sv]
// ----------------------------------------------------------------------------
// ssm_queue
// Short command FIFO that decouples the front from the back sequencer.
// ----------------------------------------------------------------------------
module ssm_queue import ssm_pkg::*; #(
  parameter int DEPTH = QDEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = count == CW'(DEPTH);
  assign q_valid = count != '0;
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[design/ssm_back.sv]
// ----------------------------------------------------------------------------
// ssm_back
// Sequencer that owns the sparse and dense memories and the held count,
// runs one command at a time and hands out one result per command.
// ----------------------------------------------------------------------------
module ssm_back import ssm_pkg::*; #(
  parameter int ID_SPACE    = ID_SPACE_DEF,
  parameter int DENSE_DEPTH = DENSE_DEPTH_DEF,
  parameter int GEN_BITS    = GEN_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  cmd_t    q_cmd,
  output logic    pop,
  output logic    clearing,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  // Only ids reachable through an 8-bit field need a sparse entry.
  localparam int SP_DEPTH = (ID_SPACE < (1 << ID_W)) ? ID_SPACE : (1 << ID_W);
  localparam int SPW      = $clog2(SP_DEPTH);
  localparam int DW       = $clog2(DENSE_DEPTH);
  localparam int CW       = $clog2(DENSE_DEPTH + 1);
  localparam int GSW      = (GEN_BITS < GEN_W) ? GEN_BITS : GEN_W;

  typedef struct packed {
    logic          valid;
    logic [DW-1:0] slot;
  } sp_entry_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [GSW-1:0]  gen;
  } dn_entry_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_MATCH = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t         state;
  state_t         state_next;
  cmd_t           cmd;
  logic [CW-1:0]  held;
  logic [SPW-1:0] clr_idx;
  logic           held_inc;
  logic           held_dec;

  sp_entry_t      sp_mem [SP_DEPTH];
  sp_entry_t      sp_rd;
  logic           sp_re;
  logic [SPW-1:0] sp_ra;
  logic           sp_we;
  logic [SPW-1:0] sp_wa;
  sp_entry_t      sp_wd;

  dn_entry_t      dn_mem [DENSE_DEPTH];
  dn_entry_t      dn_rd_a;
  dn_entry_t      dn_rd_b;
  logic           dn_re_a;
  logic           dn_re_b;
  logic [DW-1:0]  dn_ra_a;
  logic [DW-1:0]  dn_ra_b;
  logic           dn_we;
  logic [DW-1:0]  dn_wa;
  dn_entry_t      dn_wd;

  logic [DW-1:0]  last;
  logic           full;
  logic           match;

  assign clearing = state == S_CLEAR;
  assign last     = DW'(held - CW'(1));
  assign full     = held == CW'(DENSE_DEPTH);
  assign match    = (dn_rd_a.id == cmd.id) && (dn_rd_a.gen == cmd.gen[GSW-1:0]) &&
                    (CW'(sp_rd.slot) < held);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    held_inc   = 1'b0;
    held_dec   = 1'b0;
    sp_re      = 1'b0;
    sp_ra      = q_cmd.id[SPW-1:0];
    sp_we      = 1'b0;
    sp_wa      = cmd.id[SPW-1:0];
    sp_wd      = '0;
    dn_re_a    = 1'b0;
    dn_ra_a    = sp_rd.slot;
    dn_re_b    = 1'b0;
    dn_ra_b    = last;
    dn_we      = 1'b0;
    dn_wa      = DW'(held);
    dn_wd      = '{id: cmd.id, gen: cmd.gen[GSW-1:0]};
    res_valid  = 1'b0;
    res        = '{status: ST_ABSENT, dense_index: '0, move_payload: 1'b0,
                   moved_from_index: '0, active_count: CNT_W'(held)};
    unique case (state)
      S_CLEAR: begin
        sp_we = 1'b1;
        sp_wa = clr_idx;
        if (clr_idx == SPW'(SP_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          sp_re      = 1'b1;
          dn_re_b    = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        unique case (cmd.op)
          OP_ADD: begin
            res_valid = 1'b1;
            if (sp_rd.valid) begin
              res.status = ST_PRESENT;
            end else if (full) begin
              res.status = ST_FULL;
            end else begin
              res.status       = ST_OK;
              res.dense_index  = IDX_W'(held);
              res.active_count = CNT_W'(held + CW'(1));
              if (res_ready) begin
                dn_we    = 1'b1;
                sp_we    = 1'b1;
                sp_wd    = '{valid: 1'b1, slot: DW'(held)};
                held_inc = 1'b1;
              end
            end
            if (res_ready) begin
              state_next = S_IDLE;
            end
          end
          OP_REMOVE, OP_TEST: begin
            if (!sp_rd.valid) begin
              res_valid = 1'b1;
              if (res_ready) begin
                state_next = S_IDLE;
              end
            end else begin
              dn_re_a    = 1'b1;
              state_next = S_MATCH;
            end
          end
          default: begin
            res_valid = 1'b1;
            if (res_ready) begin
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_MATCH: begin
        if (cmd.op == OP_REMOVE && match) begin
          // Swap the last entry into the freed slot and repoint its id.
          if (sp_rd.slot != last) begin
            dn_we = 1'b1;
            dn_wa = sp_rd.slot;
            dn_wd = dn_rd_b;
            sp_we = 1'b1;
            sp_wa = dn_rd_b.id[SPW-1:0];
            sp_wd = '{valid: 1'b1, slot: sp_rd.slot};
          end
          held_dec   = 1'b1;
          state_next = S_FIN;
        end else begin
          res_valid = 1'b1;
          if (match) begin
            res.status      = ST_OK;
            res.dense_index = IDX_W'(sp_rd.slot);
          end
          if (res_ready) begin
            state_next = S_IDLE;
          end
        end
      end
      S_FIN: begin
        res_valid   = 1'b1;
        res.status  = ST_OK;
        res.dense_index = IDX_W'(sp_rd.slot);
        if (CW'(sp_rd.slot) != held) begin
          res.move_payload     = 1'b1;
          res.moved_from_index = IDX_W'(held);
        end
        if (res_ready) begin
          sp_we      = 1'b1;
          sp_wd      = '0;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      held    <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + SPW'(1);
      end
      if (held_inc) begin
        held <= held + CW'(1);
      end else if (held_dec) begin
        held <= held - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (sp_we) begin
      sp_mem[sp_wa] <= sp_wd;
    end
    if (sp_re) begin
      sp_rd <= sp_mem[sp_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (dn_we) begin
      dn_mem[dn_wa] <= dn_wd;
    end
    if (dn_re_a) begin
      dn_rd_a <= dn_mem[dn_ra_a];
    end
    if (dn_re_b) begin
      dn_rd_b <= dn_mem[dn_ra_b];
    end
  end

endmodule

[design/ssm_checker.sv]
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks on the sparse-set membership core, bound to the top.
// ----------------------------------------------------------------------------
module ssm_checker import ssm_pkg::*; #(
  parameter int DENSE_DEPTH = DENSE_DEPTH_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       status,
  input logic [IDX_W-1:0] dense_index,
  input logic             move_payload,
  input logic [IDX_W-1:0] moved_from_index,
  input logic [CNT_W-1:0] active_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(dense_index) && $stable(active_count))
    else $error("result beat changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("input taken during sparse clear sweep");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !move_payload && dense_index == '0 &&
      moved_from_index == '0)
    else $error("failed operation reports slot or move");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> active_count == CNT_W'(DENSE_DEPTH))
    else $error("table full reported below capacity");

endmodule

bind sparse_set_membership_core ssm_checker #(
  .DENSE_DEPTH (DENSE_DEPTH)
) u_ssm_checker (
  .clk              (clk),
  .rst              (rst),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .status           (status),
  .dense_index      (dense_index),
  .move_payload     (move_payload),
  .moved_from_index (moved_from_index),
  .active_count     (active_count)
);

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sparse-set membership core. A queued driver
// feeds add, remove, test and unused-code beats, a table model in the bench
// works out each result at acceptance, and a monitor checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ssm_pkg::*;

  // Code the block must ignore; it is not part of func_t.
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam int NUM_IDS    = ID_SPACE_DEF;
  localparam int NUM_SLOTS  = DENSE_DEPTH_DEF;
  // Cycles without any handshake before the run is declared hung. Covers the
  // sweep after reset, the long receiver hold-off and heavy random stalls.
  localparam int IDLE_LIMIT = 4000;
  // Cycles to wait after the last result.
  localparam int TAIL_CYCLES = 20;
  // Long hold-off of the receiver, started when this many results are in.
  localparam int HOLD_AT  = 700;
  localparam int HOLD_LEN = 400;

  typedef struct {
    logic [1:0]       fn;
    logic [ID_W-1:0]  id;
    logic [GEN_W-1:0] gen;
  } ssm_beat_t;

  // Clock and reset. Reset is asserted once, at time zero.
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  // Block pins, all known from the start.
  logic             in_valid          = 1'b0;
  logic             in_stall;
  logic [1:0]       func              = '0;
  logic [ID_W-1:0]  entity_id         = '0;
  logic [GEN_W-1:0] entity_generation = '0;
  logic             out_valid;
  logic             out_stall         = 1'b0;
  logic [1:0]       status;
  logic [IDX_W-1:0] dense_index;
  logic             move_payload;
  logic [IDX_W-1:0] moved_from_index;
  logic [CNT_W-1:0] active_count;

  sparse_set_membership_core i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .func              (func),
    .entity_id         (entity_id),
    .entity_generation (entity_generation),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .dense_index       (dense_index),
    .move_payload      (move_payload),
    .moved_from_index  (moved_from_index),
    .active_count      (active_count)
  );

  // Queues between the stimulus, the driver and the monitor.
  ssm_beat_t pending_beats[$];
  result_t   expected_results[$];

  // Idle ratios in percent, set per phase by the stimulus block.
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  int errors       = 0;
  int beats_sent   = 0;
  int results_seen = 0;
  int hold_left    = 0;
  int idle_cycles  = 0;
  int peak_count   = 0;
  int move_count   = 0;

  // --------------------------------------------------------------------------
  // Table model: valid bit and dense slot per id, id and generation per slot.
  // Updated in acceptance order, which is also the order results come out.
  // --------------------------------------------------------------------------
  logic             tbl_valid     [NUM_IDS];
  logic [IDX_W-1:0] tbl_slot      [NUM_IDS];
  logic [ID_W-1:0]  dense_id_mem  [NUM_SLOTS];
  logic [GEN_W-1:0] dense_gen_mem [NUM_SLOTS];
  logic [CNT_W-1:0] tbl_count = '0;

  initial begin
    for (int i = 0; i < NUM_IDS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_slot[i]  = '0;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      dense_id_mem[i]  = '0;
      dense_gen_mem[i] = '0;
    end
  end

  function automatic result_t compute_membership_result(logic [1:0] fn,
                                                        logic [ID_W-1:0] id,
                                                        logic [GEN_W-1:0] gen);
    result_t          r;
    logic             hit;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] last;
    logic [CNT_W-1:0] cnt_less;
    logic [ID_W-1:0]  rid;
    r.status           = ST_ABSENT;
    r.dense_index      = '0;
    r.move_payload     = 1'b0;
    r.moved_from_index = '0;
    slot = tbl_slot[id];
    // A hit needs a valid sparse entry pointing inside the live range at a
    // dense entry with the same id and generation.
    hit = tbl_valid[id] && ({1'b0, slot} < tbl_count) &&
          (dense_id_mem[slot] == id) && (dense_gen_mem[slot] == gen);
    case (fn)
      FN_ADD: begin
        if (tbl_valid[id]) begin
          r.status = ST_PRESENT;
        end else if (tbl_count >= CNT_W'(NUM_SLOTS)) begin
          r.status = ST_FULL;
        end else begin
          dense_id_mem[tbl_count[IDX_W-1:0]]  = id;
          dense_gen_mem[tbl_count[IDX_W-1:0]] = gen;
          tbl_valid[id]  = 1'b1;
          tbl_slot[id]   = tbl_count[IDX_W-1:0];
          r.dense_index  = tbl_count[IDX_W-1:0];
          tbl_count      = tbl_count + 1'b1;
          r.status       = ST_OK;
        end
      end
      FN_REMOVE: begin
        if (tbl_count != '0 && hit) begin
          cnt_less = tbl_count - 1'b1;
          last     = cnt_less[IDX_W-1:0];
          // Swap and pop: the last entry fills the hole and is repointed.
          if (slot != last) begin
            rid                 = dense_id_mem[last];
            dense_id_mem[slot]  = rid;
            dense_gen_mem[slot] = dense_gen_mem[last];
            tbl_slot[rid]       = slot;
            r.move_payload      = 1'b1;
            r.moved_from_index  = last;
          end
          tbl_valid[id] = 1'b0;
          tbl_slot[id]  = '0;
          tbl_count     = cnt_less;
          r.dense_index = slot;
          r.status      = ST_OK;
        end
      end
      FN_TEST: begin
        if (hit) begin
          r.dense_index = slot;
          r.status      = ST_OK;
        end
      end
      default: begin
      end
    endcase
    r.active_count = tbl_count;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus plan: a light copy of which ids are held and with what
  // generation, so that removes and tests can be aimed at live entities.
  // --------------------------------------------------------------------------
  logic             plan_present [NUM_IDS];
  logic [GEN_W-1:0] plan_gen     [NUM_IDS];
  int               plan_count = 0;

  task automatic push_beat(logic [1:0] fn, logic [ID_W-1:0] id, logic [GEN_W-1:0] gen);
    ssm_beat_t b;
    b.fn  = fn;
    b.id  = id;
    b.gen = gen;
    pending_beats.push_back(b);
    if (fn == FN_ADD && !plan_present[id] && plan_count < NUM_SLOTS) begin
      plan_present[id] = 1'b1;
      plan_gen[id]     = gen;
      plan_count++;
    end else if (fn == FN_REMOVE && plan_present[id] && plan_gen[id] == gen) begin
      plan_present[id] = 1'b0;
      plan_count--;
    end
  endtask

  // Scan from a random start for an id that is (or is not) held.
  function automatic logic [ID_W-1:0] pick_id(logic want_present);
    logic [ID_W-1:0] start;
    logic [ID_W-1:0] idx;
    start = ID_W'($urandom_range(NUM_IDS - 1));
    for (int i = 0; i < NUM_IDS; i++) begin
      idx = start + ID_W'(i);
      if (plan_present[idx] == want_present) return idx;
    end
    return start;
  endfunction

  // Aim a remove or test at a live entity most of the time, sometimes with a
  // flipped generation; otherwise use a random id.
  task automatic push_aimed(logic [1:0] fn);
    logic [ID_W-1:0]  id;
    logic [GEN_W-1:0] gen;
    if (plan_count > 0 && $urandom_range(9) < 8) begin
      id  = pick_id(1'b1);
      gen = plan_gen[id];
      if ($urandom_range(7) == 0) gen = gen ^ GEN_W'(1 << $urandom_range(GEN_W - 1));
    end else begin
      id  = ID_W'($urandom);
      gen = GEN_W'($urandom);
    end
    push_beat(fn, id, gen);
  endtask

  task automatic push_random_mix(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        if (plan_count < NUM_SLOTS && $urandom_range(9) != 0)
          push_beat(FN_ADD, pick_id(1'b0), GEN_W'($urandom));
        else
          push_beat(FN_ADD, ID_W'($urandom), GEN_W'($urandom));
      end else if (r < 68) begin
        push_aimed(FN_REMOVE);
      end else if (r < 92) begin
        push_aimed(FN_TEST);
      end else begin
        push_beat(2'($urandom_range(3)), ID_W'($urandom), GEN_W'($urandom));
      end
    end
  endtask

  // Hold the sender until every queued beat is in and every result is out,
  // then let the pipeline settle. Polled at the falling edge so that all
  // rising-edge updates are visible.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: predict each accepted beat, then offer the next one unless the
  // sender idles. A stalled beat holds its payload untouched.
  // --------------------------------------------------------------------------
  ssm_beat_t drv_cur = '{fn: '0, id: '0, gen: '0};

  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && !in_stall) begin
        expected_results.push_back(
          compute_membership_result(drv_cur.fn, drv_cur.id, drv_cur.gen));
        if (int'(tbl_count) > peak_count) peak_count = int'(tbl_count);
        beats_sent++;
        nv = 1'b0;
      end
      if (!nv && pending_beats.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        drv_cur = pending_beats.pop_front();
        nv      = 1'b1;
      end
      in_valid          <= nv;
      func              <= drv_cur.fn;
      entity_id         <= drv_cur.id;
      entity_generation <= drv_cur.gen;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted result beat with the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    logic    ns;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: expected none, actual status %0d",
                   $time, status);
        end else begin
          want = expected_results.pop_front();
          check_field("status", int'(want.status), int'(status));
          check_field("dense_index", int'(want.dense_index), int'(dense_index));
          check_field("move_payload", int'(want.move_payload), int'(move_payload));
          check_field("moved_from_index", int'(want.moved_from_index),
                      int'(moved_from_index));
          check_field("active_count", int'(want.active_count), int'(active_count));
          if (want.move_payload) move_count++;
        end
        // Start the long hold-off once; the sender keeps offering meanwhile.
        if (results_seen == HOLD_AT) hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        ns = 1'b1;
        hold_left--;
      end else begin
        ns = ($urandom_range(99) < rcv_idle_pct);
      end
      out_stall <= ns;
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed beats, then three random phases with different idle
  // patterns, the last one filling the table to capacity and emptying it.
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < NUM_IDS; i++) begin
      plan_present[i] = 1'b0;
      plan_gen[i]     = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase one: sender idles lightly, receiver heavily.
    snd_idle_pct = 30;
    rcv_idle_pct = 84;

    // Empty table: remove and test miss, unused code is ignored.
    push_beat(FN_REMOVE, 8'h00, 8'h00);
    push_beat(FN_TEST,   8'hFF, 8'hFF);
    push_beat(FN_UNUSED, 8'h05, 8'h00);
    // Extremes of id and generation.
    push_beat(FN_ADD,    8'h00, 8'h00);
    push_beat(FN_ADD,    8'hFF, 8'hFF);
    // Add of a present id with another generation.
    push_beat(FN_ADD,    8'h00, 8'h07);
    push_beat(FN_TEST,   8'h00, 8'h00);
    push_beat(FN_TEST,   8'hFF, 8'hFF);
    // Generation mismatch on test and remove.
    push_beat(FN_TEST,   8'hFF, 8'hFE);
    push_beat(FN_REMOVE, 8'hFF, 8'h00);
    push_beat(FN_ADD,    8'h55, 8'hAA);
    push_beat(FN_ADD,    8'hAA, 8'h55);
    // Remove from the front: the last slot moves into slot zero.
    push_beat(FN_REMOVE, 8'h00, 8'h00);
    push_beat(FN_TEST,   8'hAA, 8'h55);
    push_beat(FN_TEST,   8'h00, 8'h00);
    // Unused code on a live entity changes nothing.
    push_beat(FN_UNUSED, 8'h55, 8'hAA);
    // Removal of the last slot: no payload move.
    push_beat(FN_ADD,    8'h10, 8'h01);
    push_beat(FN_REMOVE, 8'h10, 8'h01);
    push_beat(FN_REMOVE, 8'hFF, 8'hFF);
    push_beat(FN_REMOVE, 8'h55, 8'hAA);
    push_beat(FN_REMOVE, 8'hAA, 8'h55);
    push_beat(FN_TEST,   8'hAA, 8'h55);
    push_random_mix(500);
    wait_drained();

    // Phase two: the other way round; the long receiver hold-off falls here.
    snd_idle_pct = 84;
    rcv_idle_pct = 30;
    push_random_mix(500);
    wait_drained();

    // Phase three: no idling. Fill the table, probe it when full, empty it.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    while (plan_count < NUM_SLOTS) push_beat(FN_ADD, pick_id(1'b0), GEN_W'($urandom));
    wait_drained();
    for (int k = 0; k < 30; k++) begin
      if (k % 3 == 0) push_beat(FN_ADD, ID_W'($urandom), GEN_W'($urandom));
      else push_aimed(FN_TEST);
    end
    push_beat(FN_UNUSED, 8'hFF, 8'hFF);
    while (plan_count > 0) push_aimed(FN_REMOVE);
    push_beat(FN_REMOVE, 8'h00, 8'h00);
    push_random_mix(250);
    wait_drained();

    $display("Run covered %0d beats and %0d checked results, table occupancy up to %0d of %0d,",
             beats_sent, results_seen, peak_count, NUM_SLOTS);
    $display("with %0d swap-and-pop moves and %0d mismatches.", move_count, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
